[rtl/scbd_pkg.sv]
package scbd_pkg;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  localparam logic [7:0] CMD_RELAYS_ON = 8'h4C;
  localparam logic [7:0] CMD_RELAYS_OFF = 8'h6C;
  localparam logic [7:0] CMD_RELAY1_ON = 8'h45;
  localparam logic [7:0] CMD_RELAY1_OFF = 8'h65;
  localparam logic [7:0] CMD_RELAY2_ON = 8'h46;
  localparam logic [7:0] CMD_RELAY2_OFF = 8'h66;
  localparam logic [7:0] CMD_BUZZER_ON = 8'h47;
  localparam logic [7:0] CMD_BUZZER_OFF = 8'h67;
  localparam logic [7:0] CMD_LED1_ON = 8'h41;
  localparam logic [7:0] CMD_LED1_OFF = 8'h61;
  localparam logic [7:0] CMD_LED2_ON = 8'h42;
  localparam logic [7:0] CMD_LED2_OFF = 8'h62;
  localparam logic [7:0] CMD_LED3_ON = 8'h43;
  localparam logic [7:0] CMD_LED3_OFF = 8'h63;
  localparam logic [7:0] CMD_LED4_ON = 8'h44;
  localparam logic [7:0] CMD_LED4_OFF = 8'h64;

  localparam logic [2:0] DIGITS_IDLE = 3'd0;
  localparam logic [2:0] DIGIT_FIRST = 3'd1;
  localparam logic [2:0] DIGIT_LAST = 3'd6;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       color_updated;
    logic [1:0] relay_bits;
    logic       buzzer_on;
    logic [3:0] led_bits;
    logic       text_write;
    logic [4:0] text_pos;
    logic [7:0] text_char;
    logic       line_done;
  } result_t;

  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) v = 4'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 4'(ch - 8'h37);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 4'(ch - 8'h57);
    return v;
  endfunction

endpackage

[rtl/serial_command_byte_decoder_top.sv]
// Each result is registered in the output register, or in the skid entry while the output is held.
// Throughput: one byte per cycle while in_stall is low; a two-entry output
// buffer lets a byte be taken while one result is still waiting.
// Reset (synchronous, active high) clears the color command, the levels, the
// text count, relays, buzzer and LEDs, and empties the output buffer.
module serial_command_byte_decoder_top #(
  parameter int TEXT_MAX = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       leds_locked,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_level,
  output logic [7:0] green_level,
  output logic [7:0] blue_level,
  output logic       color_updated,
  output logic [1:0] relay_bits,
  output logic       buzzer_on,
  output logic [3:0] led_bits,
  output logic       text_write,
  output logic [4:0] text_pos,
  output logic [7:0] text_char,
  output logic       line_done
);
  import scbd_pkg::*;

  localparam logic [8:0] TextLimit = 9'(TEXT_MAX);

  logic [2:0] digit_count, digit_count_next;
  logic [3:0] nibbles [5];
  logic       nibble_we;
  logic [2:0] nibble_idx;
  logic [3:0] digit_val;
  logic [7:0] levels [3];
  logic [7:0] levels_next [3];
  logic [4:0] text_count, text_count_next;
  logic [1:0] relays, relays_next;
  logic       buzzer, buzzer_next;
  logic [3:0] leds, leds_next;

  result_t    res_new, res_out, res_skid;
  logic       skid_full;
  logic       in_fire;

  assign in_stall = skid_full;
  assign in_fire = in_valid && !skid_full;

  always_comb begin
    digit_count_next = digit_count;
    levels_next = levels;
    text_count_next = text_count;
    relays_next = relays;
    buzzer_next = buzzer;
    leds_next = leds;
    nibble_we = 1'b0;
    nibble_idx = digit_count - 3'd1;
    digit_val = hex_value(rx_byte);
    res_new = '0;

    priority if (rx_byte == CH_HASH) begin
      digit_count_next = DIGIT_FIRST;
    end else if (digit_count != DIGITS_IDLE) begin
      if (digit_count == DIGIT_LAST) begin
        levels_next[0] = {nibbles[0], nibbles[1]};
        levels_next[1] = {nibbles[2], nibbles[3]};
        levels_next[2] = {nibbles[4], digit_val};
        digit_count_next = DIGITS_IDLE;
        res_new.color_updated = 1'b1;
      end else begin
        nibble_we = 1'b1;
        digit_count_next = digit_count + 3'd1;
      end
    end else if (rx_byte == CH_CR) begin
      res_new.line_done = 1'b1;
      res_new.text_pos = text_count;
      text_count_next = '0;
    end else if (rx_byte >= CH_PRINT_LO && rx_byte <= CH_PRINT_HI &&
                 {4'd0, text_count} < TextLimit) begin
      res_new.text_write = 1'b1;
      res_new.text_pos = text_count;
      res_new.text_char = rx_byte;
      text_count_next = text_count + 5'd1;
    end else begin
      unique case (rx_byte)
        CMD_RELAYS_ON:  relays_next = 2'b11;
        CMD_RELAYS_OFF: relays_next = 2'b00;
        CMD_RELAY1_ON:  relays_next = relays | 2'b01;
        CMD_RELAY1_OFF: relays_next = relays & 2'b10;
        CMD_RELAY2_ON:  relays_next = relays | 2'b10;
        CMD_RELAY2_OFF: relays_next = relays & 2'b01;
        CMD_BUZZER_ON:  buzzer_next = 1'b1;
        CMD_BUZZER_OFF: buzzer_next = 1'b0;
        default: ;
      endcase
      if (!leds_locked) begin
        unique case (rx_byte)
          CMD_LED1_ON:  leds_next = leds | 4'b0001;
          CMD_LED1_OFF: leds_next = leds & 4'b1110;
          CMD_LED2_ON:  leds_next = leds | 4'b0010;
          CMD_LED2_OFF: leds_next = leds & 4'b1101;
          CMD_LED3_ON:  leds_next = leds | 4'b0100;
          CMD_LED3_OFF: leds_next = leds & 4'b1011;
          CMD_LED4_ON:  leds_next = leds | 4'b1000;
          CMD_LED4_OFF: leds_next = leds & 4'b0111;
          default: ;
        endcase
      end
    end

    res_new.red_level = levels_next[0];
    res_new.green_level = levels_next[1];
    res_new.blue_level = levels_next[2];
    res_new.relay_bits = relays_next;
    res_new.buzzer_on = buzzer_next;
    res_new.led_bits = leds_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= DIGITS_IDLE;
      levels <= '{default: 8'd0};
      text_count <= '0;
      relays <= '0;
      buzzer <= 1'b0;
      leds <= '0;
    end else if (in_fire) begin
      digit_count <= digit_count_next;
      levels <= levels_next;
      text_count <= text_count_next;
      relays <= relays_next;
      buzzer <= buzzer_next;
      leds <= leds_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && nibble_we) begin
      nibbles[nibble_idx] <= digit_val;
    end
  end

  // The skid entry fills only when a transfer arrives while the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_full) begin
        res_out <= res_skid;
      end else if (in_fire) begin
        res_out <= res_new;
      end
    end else if (in_fire) begin
      res_skid <= res_new;
    end
  end

  assign red_level = res_out.red_level;
  assign green_level = res_out.green_level;
  assign blue_level = res_out.blue_level;
  assign color_updated = res_out.color_updated;
  assign relay_bits = res_out.relay_bits;
  assign buzzer_on = res_out.buzzer_on;
  assign led_bits = res_out.led_bits;
  assign text_write = res_out.text_write;
  assign text_pos = res_out.text_pos;
  assign text_char = res_out.text_char;
  assign line_done = res_out.line_done;

endmodule

[rtl/scbd_checker.sv]
module scbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_level,
  input logic [7:0] green_level,
  input logic [7:0] blue_level,
  input logic       color_updated,
  input logic [1:0] relay_bits,
  input logic       buzzer_on,
  input logic [3:0] led_bits,
  input logic       text_write,
  input logic [4:0] text_pos,
  input logic [7:0] text_char,
  input logic       line_done
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("Output buffer not empty after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(red_level) &&
      $stable(green_level) && $stable(blue_level) && $stable(color_updated) &&
      $stable(relay_bits) && $stable(buzzer_on) && $stable(led_bits) &&
      $stable(text_write) && $stable(text_pos) && $stable(text_char) &&
      $stable(line_done))
    else $error("Stalled result changed.");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> $countones({color_updated, text_write, line_done}) <= 1)
    else $error("More than one action reported for one byte.");

  a_char_only_on_write: assert property (@(posedge clk) disable iff (rst)
      out_valid && !text_write |-> text_char == 8'd0)
    else $error("Text character reported without a text write.");

  a_leds_locked_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_stall ##1 out_valid && color_updated |->
      led_bits == $past(led_bits) && relay_bits == $past(relay_bits))
    else $error("Color update changed relays or LEDs.");

endmodule

bind serial_command_byte_decoder_top scbd_checker u_scbd_checker (.*);

[sim/testbench.sv]
module testbench;
  import scbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_MAX = 20;
  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_AT = 420;
  localparam int LONG_HOLD = 60;
  localparam int QUIET_TAIL = 80;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic [7:0] rx;
    logic       locked;
    bit         settle_first;
  } byte_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       leds_locked = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic       color_updated;
  logic [1:0] relay_bits;
  logic       buzzer_on;
  logic [3:0] led_bits;
  logic       text_write;
  logic [4:0] text_pos;
  logic [7:0] text_char;
  logic       line_done;

  byte_item_t byte_queue[$];
  result_t    pending_results[$];
  int         n_items = 0;
  int         bytes_taken = 0;
  int         results_taken = 0;
  int         errors = 0;
  int         send_gap = 0;
  int         sink_gap = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         idle_cycles = 0;

  logic [2:0] digit_pos = DIGITS_IDLE;
  logic [3:0] nibbles[6];
  logic [7:0] levels[3] = '{8'd0, 8'd0, 8'd0};
  logic [4:0] line_len = 5'd0;
  logic [1:0] relay_state = 2'b00;
  logic       buzzer_now = 1'b0;
  logic [3:0] led_state = 4'd0;

  logic [7:0] cmd_codes[18] = '{
    CMD_RELAYS_ON, CMD_RELAYS_OFF, CMD_RELAY1_ON, CMD_RELAY1_OFF, CMD_RELAY2_ON,
    CMD_RELAY2_OFF, CMD_BUZZER_ON, CMD_BUZZER_OFF, CMD_LED1_ON, CMD_LED1_OFF,
    CMD_LED2_ON, CMD_LED2_OFF, CMD_LED3_ON, CMD_LED3_OFF, CMD_LED4_ON,
    CMD_LED4_OFF, CMD_RELAYS_ON, CMD_BUZZER_ON
  };
  string hex_chars = "0123456789ABCDEFabcdef";

  serial_command_byte_decoder_top #(
    .TEXT_MAX(TEXT_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .leds_locked(leds_locked),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red_level(red_level),
    .green_level(green_level),
    .blue_level(blue_level),
    .color_updated(color_updated),
    .relay_bits(relay_bits),
    .buzzer_on(buzzer_on),
    .led_bits(led_bits),
    .text_write(text_write),
    .text_pos(text_pos),
    .text_char(text_char),
    .line_done(line_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [3:0] digit_worth(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch[3:0];
    if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) return 4'(ch[3:0] + 4'd9);
    return 4'd0;
  endfunction

  function automatic void obey_command(input logic [7:0] ch, input logic locked);
    case (ch)
      CMD_RELAYS_ON:  relay_state = 2'b11;
      CMD_RELAYS_OFF: relay_state = 2'b00;
      CMD_RELAY1_ON:  relay_state[0] = 1'b1;
      CMD_RELAY1_OFF: relay_state[0] = 1'b0;
      CMD_RELAY2_ON:  relay_state[1] = 1'b1;
      CMD_RELAY2_OFF: relay_state[1] = 1'b0;
      CMD_BUZZER_ON:  buzzer_now = 1'b1;
      CMD_BUZZER_OFF: buzzer_now = 1'b0;
      default: ;
    endcase
    if (!locked) begin
      case (ch)
        CMD_LED1_ON:  led_state[0] = 1'b1;
        CMD_LED1_OFF: led_state[0] = 1'b0;
        CMD_LED2_ON:  led_state[1] = 1'b1;
        CMD_LED2_OFF: led_state[1] = 1'b0;
        CMD_LED3_ON:  led_state[2] = 1'b1;
        CMD_LED3_OFF: led_state[2] = 1'b0;
        CMD_LED4_ON:  led_state[3] = 1'b1;
        CMD_LED4_OFF: led_state[3] = 1'b0;
        default: ;
      endcase
    end
  endfunction

  function automatic result_t decode_byte(input logic [7:0] ch, input logic locked);
    result_t r;
    r = '0;
    if (ch == CH_HASH) begin
      digit_pos = DIGIT_FIRST;
    end else if (digit_pos != DIGITS_IDLE) begin
      nibbles[digit_pos - 3'd1] = digit_worth(ch);
      if (digit_pos == DIGIT_LAST) begin
        for (int i = 0; i < 3; i++) levels[i] = {nibbles[2 * i], nibbles[2 * i + 1]};
        digit_pos = DIGITS_IDLE;
        r.color_updated = 1'b1;
      end else begin
        digit_pos = digit_pos + 3'd1;
      end
    end else if (ch == CH_CR) begin
      r.line_done = 1'b1;
      r.text_pos = line_len;
      line_len = 5'd0;
    end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI && line_len < TEXT_MAX) begin
      r.text_write = 1'b1;
      r.text_pos = line_len;
      r.text_char = ch;
      line_len = line_len + 5'd1;
    end else begin
      obey_command(ch, locked);
    end
    r.red_level = levels[0];
    r.green_level = levels[1];
    r.blue_level = levels[2];
    r.relay_bits = relay_state;
    r.buzzer_on = buzzer_now;
    r.led_bits = led_state;
    return r;
  endfunction

  function automatic bit calm_phase(input int n);
    return n >= n_items - QUIET_TAIL || (n / 64) % 4 == 3 ||
           (n >= HOLD_AT && n < HOLD_AT + 30);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    byte_item_t item;
    item.rx = b;
    item.locked = ($urandom_range(0, 3) == 0);
    item.settle_first = 1'b0;
    byte_queue.push_back(item);
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  initial begin
    int directed_len;
    int n;
    add_byte(CH_CR);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(CH_PRINT_LO);
    add_byte(CH_PRINT_HI);
    add_byte(8'h7F);
    add_byte(CH_HASH);
    add_byte("F");
    add_byte("f");
    add_byte("0");
    add_byte("9");
    add_byte("a");
    add_byte("Z");
    add_byte(CH_HASH);
    add_byte("1");
    add_byte(CH_HASH);
    add_byte("A");
    add_byte("b");
    add_byte(CH_CR);
    add_byte("3");
    add_byte("4");
    add_byte("5");
    add_byte("6");
    directed_len = byte_queue.size();
    while (byte_queue.size() < directed_len + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          add_byte(CH_HASH);
          for (int i = 0; i < 6; i++) begin
            n = $urandom_range(0, 19);
            if (n < 17) add_byte(8'(hex_chars[$urandom_range(0, 21)]));
            else if (n < 19) add_byte(8'($urandom_range(0, 255)));
            else add_byte(CH_HASH);
          end
        end
        3, 4, 5: begin
          n = $urandom_range(0, 22);
          for (int i = 0; i < n; i++) add_byte(8'($urandom_range(32, 126)));
        end
        6, 7: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) add_byte(cmd_codes[$urandom_range(0, 17)]);
        end
        8: add_byte(CH_CR);
        default: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
    n_items = byte_queue.size();
    byte_queue[directed_len].settle_first = 1'b1;
    byte_queue[300].settle_first = 1'b1;
    byte_queue[600].settle_first = 1'b1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (bytes_taken != n_items || results_taken != n_items);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    bit took;
    took = in_valid && !in_stall;
    if (took) begin
      pending_results.push_back(decode_byte(rx_byte, leds_locked));
      void'(byte_queue.pop_front());
      bytes_taken <= bytes_taken + 1;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took) begin
      in_valid <= 1'b1;
    end else if (send_gap != 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (byte_queue.size() == 0 ||
                 (byte_queue[0].settle_first && bytes_taken + int'(took) != results_taken)) begin
      in_valid <= 1'b0;
    end else if (!calm_phase(bytes_taken) && $urandom_range(0, 5) == 0) begin
      send_gap = $urandom_range(1, 10) - 1;
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      rx_byte <= byte_queue[0].rx;
      leds_locked <= byte_queue[0].locked;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (sink_gap != 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else if (!calm_phase(bytes_taken) && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_taken <= results_taken + 1;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result transfer with no byte waiting", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("red_level", want.red_level, red_level);
        check_field("green_level", want.green_level, green_level);
        check_field("blue_level", want.blue_level, blue_level);
        check_field("color_updated", want.color_updated, color_updated);
        check_field("relay_bits", want.relay_bits, relay_bits);
        check_field("buzzer_on", want.buzzer_on, buzzer_on);
        check_field("led_bits", want.led_bits, led_bits);
        check_field("text_write", want.text_write, text_write);
        check_field("text_pos", want.text_pos, text_pos);
        check_field("text_char", want.text_char, text_char);
        check_field("line_done", want.line_done, line_done);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
